[rtl/ccb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ccb_pkg;

  // Field widths
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned REASON_W  = 2;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset value of the three percentage registers.
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;

  // Division by 100 of a 32-bit value: (x * DIV100_MAGIC) >> DIV100_SHIFT is exact.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int unsigned DIV100_SHIFT = 37;
  localparam int unsigned QUOT_W       = TICK_W + 64 - 64 - DIV100_SHIFT + 32; // 27 bits

  // Division by 100 of a value below 43690: (y * SMALL_MAGIC) >> SMALL_SHIFT is exact.
  localparam logic [12:0] SMALL_MAGIC = 13'd5243;
  localparam int unsigned SMALL_SHIFT = 19;

  // Widths of the partial products of the scaling pipeline.
  localparam int unsigned HI_W  = QUOT_W + PCT_W;   // quotient part times percent
  localparam int unsigned LO_W  = 2 * PCT_W;        // remainder part times percent
  localparam int unsigned REQ_W = TICK_W + 1;       // scaled value fits 33 bits

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_ACCRUE = 3'd1,
    KIND_BOOST  = 3'd2,
    KIND_GRANT  = 3'd3,
    KIND_SPEND  = 3'd4
  } kind_t;

  typedef enum logic [REASON_W-1:0] {
    REASON_YIELD   = 2'd0,
    REASON_AWAIT   = 2'd1,
    REASON_PREEMPT = 2'd2
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YIELD_PCT = 3'd0,
    CFG_AWAIT_PCT = 3'd1,
    CFG_BURST_PCT = 3'd2,
    CFG_CAP       = 3'd3,
    CFG_QUANTUM   = 3'd4
  } cfg_idx_t;

  // Configuration register contents.
  typedef struct packed {
    logic [PCT_W-1:0]  yield_pct;
    logic [PCT_W-1:0]  await_pct;
    logic [PCT_W-1:0]  burst_pct;
    logic [TICK_W-1:0] credit_cap;
    logic [TICK_W-1:0] quantum_len;
  } cfg_t;

  // Prepared request handed from the scaling pipeline to the ledger.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              others;
    logic [REQ_W-1:0]  req;
  } req_t;

endpackage

`default_nettype wire

[rtl/ccb_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module ccb_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [ccb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccb_pkg::TICK_W-1:0]     cfg_data,
  output ccb_pkg::cfg_t                       cfg
);

  ccb_pkg::cfg_t cfg_r;

  // Register file; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yield_pct   <= ccb_pkg::PCT_RESET;
      cfg_r.await_pct   <= ccb_pkg::PCT_RESET;
      cfg_r.burst_pct   <= ccb_pkg::PCT_RESET;
      cfg_r.credit_cap  <= '0;
      cfg_r.quantum_len <= '0;
    end else if (cfg_valid) begin
      unique case (ccb_pkg::cfg_idx_t'(cfg_index))
        ccb_pkg::CFG_YIELD_PCT: cfg_r.yield_pct   <= cfg_data[ccb_pkg::PCT_W-1:0];
        ccb_pkg::CFG_AWAIT_PCT: cfg_r.await_pct   <= cfg_data[ccb_pkg::PCT_W-1:0];
        ccb_pkg::CFG_BURST_PCT: cfg_r.burst_pct   <= cfg_data[ccb_pkg::PCT_W-1:0];
        ccb_pkg::CFG_CAP:       cfg_r.credit_cap  <= cfg_data;
        ccb_pkg::CFG_QUANTUM:   cfg_r.quantum_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/ccb_scale_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

module ccb_scale_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic                          in_valid,
  input  wire logic [ccb_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [ccb_pkg::REASON_W-1:0]  in_reason,
  input  wire logic [ccb_pkg::TICK_W-1:0]    in_amount_ticks,
  input  wire logic [ccb_pkg::TICK_W-1:0]    in_expected_ticks,
  input  wire logic                          in_others_runnable,
  input  wire ccb_pkg::cfg_t                 cfg,
  output logic                               req_valid,
  output ccb_pkg::req_t                      req
);

  // Stage 1: input register
  logic                          v1_r;
  logic [ccb_pkg::KIND_W-1:0]    kind1_r;
  logic [ccb_pkg::REASON_W-1:0]  reason1_r;
  logic [ccb_pkg::TICK_W-1:0]    amount1_r;
  logic [ccb_pkg::TICK_W-1:0]    expected1_r;
  logic                          others1_r;

  // Stage 2: quotient of the operand by 100
  logic                          v2_r;
  logic [ccb_pkg::KIND_W-1:0]    kind2_r;
  logic                          others2_r;
  logic [ccb_pkg::TICK_W-1:0]    alt2_r;
  logic [ccb_pkg::TICK_W-1:0]    a2_r;
  logic [ccb_pkg::PCT_W-1:0]     p2_r;
  logic [ccb_pkg::QUOT_W-1:0]    aq2_r;

  // Stage 3: partial products with the percentage
  logic                          v3_r;
  logic [ccb_pkg::KIND_W-1:0]    kind3_r;
  logic                          others3_r;
  logic [ccb_pkg::TICK_W-1:0]    alt3_r;
  logic [ccb_pkg::HI_W-1:0]      hi3_r;
  logic [ccb_pkg::LO_W-1:0]      lo3_r;

  // Stage 4: prepared request
  logic                          v4_r;
  ccb_pkg::req_t                 req4_r;

  logic [ccb_pkg::TICK_W-1:0]    a1;
  logic [ccb_pkg::PCT_W-1:0]     p1;
  logic [ccb_pkg::TICK_W-1:0]    alt1;
  logic [63:0]                   prod1;
  logic [ccb_pkg::TICK_W-1:0]    aq_x100;
  logic [ccb_pkg::TICK_W-1:0]    rem2;
  logic [ccb_pkg::PCT_W-1:0]     ar2;
  logic [ccb_pkg::HI_W-1:0]      hi2;
  logic [ccb_pkg::LO_W-1:0]      lo2;
  logic [26:0]                   small_prod;
  logic [ccb_pkg::HI_W-1:0]      q3;
  ccb_pkg::req_t                 req3;

  // Operand and percentage selection. A preempted accrue scales by zero,
  // and boost carries its excess of waited over expected ticks.
  always_comb begin
    a1 = amount1_r;
    p1 = '0;
    unique case (ccb_pkg::kind_t'(kind1_r))
      ccb_pkg::KIND_ACCRUE: begin
        unique case (ccb_pkg::reason_t'(reason1_r))
          ccb_pkg::REASON_YIELD: p1 = cfg.yield_pct;
          ccb_pkg::REASON_AWAIT: p1 = cfg.await_pct;
          default:               p1 = '0;
        endcase
      end
      ccb_pkg::KIND_GRANT: begin
        a1 = cfg.quantum_len;
        p1 = cfg.burst_pct;
      end
      default: ;
    endcase
    if (ccb_pkg::kind_t'(kind1_r) == ccb_pkg::KIND_BOOST) begin
      alt1 = (amount1_r > expected1_r) ? (amount1_r - expected1_r) : '0;
    end else begin
      alt1 = amount1_r;
    end
    prod1 = 64'(a1) * 64'(ccb_pkg::DIV100_MAGIC);
  end

  // Remainder by 100 and the two partial products with the percentage.
  always_comb begin
    aq_x100 = (ccb_pkg::TICK_W'(aq2_r) << 6) + (ccb_pkg::TICK_W'(aq2_r) << 5)
            + (ccb_pkg::TICK_W'(aq2_r) << 2);
    rem2    = a2_r - aq_x100;
    ar2     = rem2[ccb_pkg::PCT_W-1:0];
    hi2     = ccb_pkg::HI_W'(aq2_r) * ccb_pkg::HI_W'(p2_r);
    lo2     = ccb_pkg::LO_W'(ar2) * ccb_pkg::LO_W'(p2_r);
  end

  // Quotient of the small product by 100, then the request value.
  always_comb begin
    small_prod = 27'(lo3_r) * 27'(ccb_pkg::SMALL_MAGIC);
    q3         = hi3_r + ccb_pkg::HI_W'(small_prod[26:ccb_pkg::SMALL_SHIFT]);
    req3.kind   = kind3_r;
    req3.others = others3_r;
    if (ccb_pkg::kind_t'(kind3_r) == ccb_pkg::KIND_ACCRUE ||
        ccb_pkg::kind_t'(kind3_r) == ccb_pkg::KIND_GRANT) begin
      req3.req = q3[ccb_pkg::REQ_W-1:0];
    end else begin
      req3.req = {1'b0, alt3_r};
    end
  end

  // Stage valid flags move together under the common advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      kind1_r     <= in_kind;
      reason1_r   <= in_reason;
      amount1_r   <= in_amount_ticks;
      expected1_r <= in_expected_ticks;
      others1_r   <= in_others_runnable;

      kind2_r     <= kind1_r;
      others2_r   <= others1_r;
      alt2_r      <= alt1;
      a2_r        <= a1;
      p2_r        <= p1;
      aq2_r       <= prod1[63:ccb_pkg::DIV100_SHIFT];

      kind3_r     <= kind2_r;
      others3_r   <= others2_r;
      alt3_r      <= alt2_r;
      hi3_r       <= hi2;
      lo3_r       <= lo2;

      req4_r      <= req3;
    end
  end

  assign req_valid = v4_r;
  assign req       = req4_r;

endmodule

`default_nettype wire

[rtl/ccb_ledger.sv]
`timescale 1ns / 1ps
`default_nettype none

module ccb_ledger (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic                          req_valid,
  input  wire ccb_pkg::req_t                 req,
  input  wire logic [ccb_pkg::TICK_W-1:0]    credit_cap,
  output logic                               out_valid,
  output logic [ccb_pkg::TICK_W-1:0]         moved_ticks,
  output logic [ccb_pkg::TICK_W-1:0]         credit_balance,
  output logic [ccb_pkg::TOTAL_W-1:0]        earned_total,
  output logic [ccb_pkg::TOTAL_W-1:0]        boost_total,
  output logic [ccb_pkg::TOTAL_W-1:0]        spent_total
);

  // The balance and totals double as the result register: they change only
  // when a new result is loaded.
  logic                          out_valid_r;
  logic [ccb_pkg::TICK_W-1:0]    moved_r,  moved_nxt;
  logic [ccb_pkg::TICK_W-1:0]    credit_r, credit_nxt;
  logic [ccb_pkg::TOTAL_W-1:0]   earned_r, earned_nxt;
  logic [ccb_pkg::TOTAL_W-1:0]   boost_r,  boost_nxt;
  logic [ccb_pkg::TOTAL_W-1:0]   spent_r,  spent_nxt;

  logic [ccb_pkg::TICK_W-1:0]    room;
  logic [ccb_pkg::TICK_W-1:0]    bound;
  logic [ccb_pkg::TICK_W-1:0]    lim;

  // Room below the cap, and the bound that applies to this kind.
  always_comb begin
    room = (credit_r >= credit_cap) ? '0 : (credit_cap - credit_r);
    if (ccb_pkg::kind_t'(req.kind) == ccb_pkg::KIND_ACCRUE ||
        ccb_pkg::kind_t'(req.kind) == ccb_pkg::KIND_BOOST) begin
      bound = room;
    end else begin
      bound = credit_r;
    end
    lim = (req.req > {1'b0, bound}) ? bound : req.req[ccb_pkg::TICK_W-1:0];
  end

  // Balance and total update for one item.
  always_comb begin
    moved_nxt  = '0;
    credit_nxt = credit_r;
    earned_nxt = earned_r;
    boost_nxt  = boost_r;
    spent_nxt  = spent_r;
    unique case (ccb_pkg::kind_t'(req.kind))
      ccb_pkg::KIND_CLEAR: begin
        credit_nxt = '0;
        earned_nxt = '0;
        boost_nxt  = '0;
        spent_nxt  = '0;
      end
      ccb_pkg::KIND_ACCRUE: begin
        moved_nxt  = lim;
        credit_nxt = credit_r + lim;
        earned_nxt = earned_r + ccb_pkg::TOTAL_W'(lim);
      end
      ccb_pkg::KIND_BOOST: begin
        moved_nxt  = lim;
        credit_nxt = credit_r + lim;
        boost_nxt  = boost_r + ccb_pkg::TOTAL_W'(lim);
      end
      ccb_pkg::KIND_GRANT: begin
        moved_nxt = req.others ? '0 : lim;
      end
      ccb_pkg::KIND_SPEND: begin
        moved_nxt  = lim;
        credit_nxt = credit_r - lim;
        spent_nxt  = spent_r + ccb_pkg::TOTAL_W'(lim);
      end
      default: ;
    endcase
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      moved_r     <= '0;
      credit_r    <= '0;
      earned_r    <= '0;
      boost_r     <= '0;
      spent_r     <= '0;
    end else if (advance) begin
      out_valid_r <= req_valid;
      if (req_valid) begin
        moved_r  <= moved_nxt;
        credit_r <= credit_nxt;
        earned_r <= earned_nxt;
        boost_r  <= boost_nxt;
        spent_r  <= spent_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign moved_ticks    = moved_r;
  assign credit_balance = credit_r;
  assign earned_total   = earned_r;
  assign boost_total    = boost_r;
  assign spent_total    = spent_r;

`ifndef SYNTH
  // A rise of the balance never takes it past the cap.
  a_rise_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (credit_r > $past(credit_r))) |-> (credit_r <= credit_cap))
    else $error("balance rose above the cap");

  // A grant query leaves the balance and the earned and spent totals untouched.
  a_grant_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_valid && (req.kind == ccb_pkg::KIND_GRANT))
    |=> ($stable(credit_r) && $stable(earned_r) && $stable(spent_r)))
    else $error("grant changed the ledger");

  // An accrue raises the balance by exactly the ticks it reports.
  a_accrue_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && req_valid && (req.kind == ccb_pkg::KIND_ACCRUE))
    |=> (credit_r == $past(credit_r) + moved_r))
    else $error("accrue balance does not match moved ticks");

  // A result waiting at the output keeps the ledger frozen.
  a_hold_ledger: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance) |=> ($stable(credit_r) && $stable(moved_r) && $stable(boost_r)))
    else $error("ledger changed while the output was stalled");
`endif

endmodule

`default_nettype wire

[rtl/cpu_credit_bank_unit.sv]
// Items pass the input, quotient, partial-product and request stages and
// the ledger's result register. Throughput: one item per cycle unless
// stalled; the balance loop is one register through clamp, add and compare.
// Backpressure stalls every stage together; in_ready follows out_ready.
// Synchronous active-low reset clears the balance, the totals and all valid
// flags, and loads the percentages with 50 and the cap and quantum with 0.
`timescale 1ns / 1ps
`default_nettype none

module cpu_credit_bank_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ccb_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [ccb_pkg::REASON_W-1:0]   in_reason,
  input  wire logic [ccb_pkg::TICK_W-1:0]     in_amount_ticks,
  input  wire logic [ccb_pkg::TICK_W-1:0]     in_expected_ticks,
  input  wire logic                           in_others_runnable,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ccb_pkg::TICK_W-1:0]          out_moved_ticks,
  output logic [ccb_pkg::TICK_W-1:0]          out_credit_balance,
  output logic [ccb_pkg::TOTAL_W-1:0]         out_earned_total,
  output logic [ccb_pkg::TOTAL_W-1:0]         out_boost_total,
  output logic [ccb_pkg::TOTAL_W-1:0]         out_spent_total,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ccb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccb_pkg::TICK_W-1:0]     cfg_data
);

  ccb_pkg::cfg_t  cfg;
  ccb_pkg::req_t  req;
  logic           req_valid;
  logic           advance;

  // The whole pipeline moves whenever the result register is free or taken.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  ccb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccb_scale_pipe u_pipe (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .in_valid           (in_valid),
    .in_kind            (in_kind),
    .in_reason          (in_reason),
    .in_amount_ticks    (in_amount_ticks),
    .in_expected_ticks  (in_expected_ticks),
    .in_others_runnable (in_others_runnable),
    .cfg                (cfg),
    .req_valid          (req_valid),
    .req                (req)
  );

  ccb_ledger u_ledger (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .req_valid      (req_valid),
    .req            (req),
    .credit_cap     (cfg.credit_cap),
    .out_valid      (out_valid),
    .moved_ticks    (out_moved_ticks),
    .credit_balance (out_credit_balance),
    .earned_total   (out_earned_total),
    .boost_total    (out_boost_total),
    .spent_total    (out_spent_total)
  );

endmodule

`default_nettype wire
